>>> src/pwmuc_pkg.sv
`timescale 1ns / 1ps

package pwmuc_pkg;

  // APB address width: six 32-bit registers at byte offsets 0x00..0x14
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned RegIdxW  = 3;

  localparam logic [RegIdxW-1:0] REG_RUN_COUNTER       = 3'd0;
  localparam logic [RegIdxW-1:0] REG_PERIOD            = 3'd1;
  localparam logic [RegIdxW-1:0] REG_COMPARE_A         = 3'd2;
  localparam logic [RegIdxW-1:0] REG_ZERO_ACTION       = 3'd3;
  localparam logic [RegIdxW-1:0] REG_PERIOD_ACTION     = 3'd4;
  localparam logic [RegIdxW-1:0] REG_COMPARE_UP_ACTION = 3'd5;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_LOW    = 2'd1,
    ACT_HIGH   = 2'd2,
    ACT_TOGGLE = 2'd3
  } action_e;

  typedef struct packed {
    logic        run_counter;
    logic [15:0] period;
    logic [15:0] compare_a;
    action_e     zero_action;
    action_e     period_action;
    action_e     compare_up_action;
  } cfg_t;

  typedef struct packed {
    logic advance;
    logic clear_counter;
  } in_t;

  typedef struct packed {
    logic        pwm_level;
    logic [15:0] counter_value;
    logic        at_zero;
    logic        at_period;
    logic        at_compare;
  } out_t;

endpackage

>>> src/pwmuc_regs.sv
`timescale 1ns / 1ps

module pwmuc_regs
  import pwmuc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t               cfg_q;
  logic               wr_en;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ApbAddrW-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RUN_COUNTER:       cfg_q.run_counter       <= pwdata[0];
        REG_PERIOD:            cfg_q.period            <= pwdata[15:0];
        REG_COMPARE_A:         cfg_q.compare_a         <= pwdata[15:0];
        REG_ZERO_ACTION:       cfg_q.zero_action       <= action_e'(pwdata[1:0]);
        REG_PERIOD_ACTION:     cfg_q.period_action     <= action_e'(pwdata[1:0]);
        REG_COMPARE_UP_ACTION: cfg_q.compare_up_action <= action_e'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_RUN_COUNTER:       prdata = {31'd0, cfg_q.run_counter};
      REG_PERIOD:            prdata = {16'd0, cfg_q.period};
      REG_COMPARE_A:         prdata = {16'd0, cfg_q.compare_a};
      REG_ZERO_ACTION:       prdata = {30'd0, cfg_q.zero_action};
      REG_PERIOD_ACTION:     prdata = {30'd0, cfg_q.period_action};
      REG_COMPARE_UP_ACTION: prdata = {30'd0, cfg_q.compare_up_action};
      default:               prdata = '0;
    endcase
  end

endmodule

>>> src/pwm_up_counter_action_qualifier.sv
`timescale 1ns / 1ps
// Channel   | Handshake                 | Payload
// ----------+---------------------------+--------------------------------
// input     | in_valid_i / in_ready_o   | in_data_i  (in_t: tick, clear)
// result    | out_valid_o / out_ready_i | out_data_o (out_t: level, count, flags)
// config    | APB psel/penable/pwrite   | paddr, pwdata, prdata
//
// One transaction per clock unless stalled: counter, shadow compare and output
// level update when the item is taken; the result appears in the next cycle.
// The result register is the only stall point; input is taken whenever that
// register is empty or being drained in the same cycle.
// Reset clears the counter, active compare, level, config and valid flag.

module pwm_up_counter_action_qualifier
  import pwmuc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t        cfg;
  logic [15:0] count_q, count_d;
  logic [15:0] act_cmp_q, act_cmp_d;
  logic        level_q, level_d;
  out_t        out_q;
  logic        out_valid_q;
  logic        accept;
  logic        moved;
  logic        ev_zero, ev_period, ev_compare;
  action_e     sel_act;

  pwmuc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // time base: clear wins over a tick
  always_comb begin
    count_d = count_q;
    moved   = 1'b0;
    if (in_data_i.clear_counter) begin
      count_d = '0;
      moved   = 1'b1;
    end else if (in_data_i.advance && cfg.run_counter) begin
      count_d = (count_q == cfg.period) ? 16'd0 : count_q + 16'd1;
      moved   = 1'b1;
    end
  end

  // shadow load happens before the compare match of the same item
  always_comb begin
    ev_zero    = moved && (count_d == 16'd0);
    act_cmp_d  = ev_zero ? cfg.compare_a : act_cmp_q;
    ev_period  = moved && (count_d == cfg.period);
    ev_compare = moved && (count_d == act_cmp_d);
  end

  // action qualifier: period > compare > zero, skipping "none" actions
  always_comb begin
    sel_act = ACT_NONE;
    if (ev_period && cfg.period_action != ACT_NONE) begin
      sel_act = cfg.period_action;
    end else if (ev_compare && cfg.compare_up_action != ACT_NONE) begin
      sel_act = cfg.compare_up_action;
    end else if (ev_zero && cfg.zero_action != ACT_NONE) begin
      sel_act = cfg.zero_action;
    end
    case (sel_act)
      ACT_LOW:    level_d = 1'b0;
      ACT_HIGH:   level_d = 1'b1;
      ACT_TOGGLE: level_d = !level_q;
      default:    level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      act_cmp_q   <= '0;
      level_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q   <= count_d;
        act_cmp_q <= act_cmp_d;
        level_q   <= level_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.pwm_level     <= level_d;
      out_q.counter_value <= count_d;
      out_q.at_zero       <= ev_zero;
      out_q.at_period     <= ev_period;
      out_q.at_compare    <= ev_compare;
    end
  end

  // a clear always lands the counter on zero with the zero event set
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.clear_counter |=> out_q.counter_value == 16'd0 && out_q.at_zero)
    else $error("clear did not produce a zero count");

  // an item that does not move the counter fires nothing and keeps the level
  a_idle_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_data_i.clear_counter && !(in_data_i.advance && cfg.run_counter)
    |=> !out_q.at_zero && !out_q.at_period && !out_q.at_compare &&
        $stable(count_q) && $stable(level_q))
    else $error("held counter produced an event");

  // plain count step not at period increments by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_data_i.clear_counter && in_data_i.advance && cfg.run_counter &&
    count_q != cfg.period |=> count_q == $past(count_q) + 16'd1)
    else $error("counter step wrong");

  // input side only blocks while a result waits
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

endmodule
